[hdl/ffbp_pkg.sv]
package ffbp_pkg;

	localparam int SIZE_W      = 31;
	localparam int HANDLE_W    = 4;
	localparam int CAP_W       = 5;
	localparam int HANDLE_RANGE = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;
	localparam logic             REG_CAP_IDX = 1'b0;

	typedef enum logic [1:0] {
		ACT_ACQUIRE = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_CLEAR   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_REUSED    = 3'd0,
		ST_NEW       = 3'd1,
		ST_RECLAIMED = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_SIZE  = 3'd4,
		ST_RELEASED  = 3'd5,
		ST_IGNORED   = 3'd6,
		ST_CLEARED   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FRESH,
		S_RECLAIM,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		logic ge_req;
		logic lt_min;
	} cmp_t;

endpackage

[hdl/ffbp_cmp.sv]
module ffbp_cmp (
	input  logic [ffbp_pkg::SIZE_W-1:0] slot_size,
	input  logic [ffbp_pkg::SIZE_W-1:0] req_size,
	input  logic [ffbp_pkg::SIZE_W-1:0] min_size,
	output ffbp_pkg::cmp_t              res
);
	import ffbp_pkg::*;

	// Shared size comparator: fit test against the request, and the running minimum
	assign res.ge_req = (slot_size >= req_size);
	assign res.lt_min = (slot_size < min_size);

endmodule

[hdl/first_fit_buffer_pool_core.sv]
// Acquire: the idle list is scanned in order, one entry at a time through one shared
// comparator, before the result is registered; release and clear are decided in S_DECODE.
// A new item is taken once the previous result is in the output register.
// Reset (arst_n low, asynchronous): pool emptied, capacity 16, output empty.
module first_fit_buffer_pool_core #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: action[1:0], request_size[32:2], handle[36:33], zero pad
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ffbp_pkg::IN_TDATA_W-1:0]     s_tdata,
	// m_tdata: status[2:0], granted_handle[6:3], granted_size[37:7], zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ffbp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ffbp_pkg::PADDR_W-1:0]        paddr,
	input  logic [ffbp_pkg::PDATA_W-1:0]        pwdata,
	output logic [ffbp_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);
	import ffbp_pkg::*;

	localparam int NSLOT = (MAX_SLOTS < HANDLE_RANGE) ? MAX_SLOTS : HANDLE_RANGE;
	localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int CW    = $clog2(NSLOT + 1);

	seq_state_t state_q, state_d;

	logic [1:0]        act_q;
	logic [SIZE_W-1:0] size_q;
	logic [HANDLE_W-1:0] handle_q;

	logic [CW-1:0]     k_q;
	logic [SW-1:0]     min_pos_q;
	logic [SIZE_W-1:0] min_size_q;
	logic              have_min_q;

	status_t             res_status_q, res_status_d;
	logic [SW-1:0]       res_slot_q, res_slot_d;
	logic [SIZE_W-1:0]   res_size_q, res_size_d;

	logic [SIZE_W-1:0] slot_size_q [NSLOT];
	logic [SW-1:0]     idle_q [NSLOT];
	logic [NSLOT-1:0]  in_use_q;
	logic [NSLOT-1:0]  busy_q;
	logic [CW-1:0]     idle_cnt_q;
	logic [CW-1:0]     used_cnt_q;
	logic [CAP_W-1:0]  cap_q;

	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;

	logic [SW-1:0]     rd_pos;
	logic [SW-1:0]     rd_slot;
	logic [SIZE_W-1:0] rd_size;
	cmp_t              cmp;

	logic [SW-1:0] free_idx;
	logic          free_any;
	logic [SW-1:0] hsel;
	logic          rel_ok;

	logic          res_en, scan_init, scan_adv, min_upd;
	logic          rel_en, clr_en, grant_en, fresh_en, size_wr_en, out_load;
	logic [SW-1:0] drop_pos;
	logic          in_xfer;
	logic          cfg_wr;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_CAP_IDX);
	assign prdata   = (paddr[2] == REG_CAP_IDX) ? PDATA_W'(cap_q) : '0;

	// One read port into the idle list, then into the size store
	assign rd_pos  = (state_q == S_RECLAIM) ? min_pos_q : k_q[SW-1:0];
	assign rd_slot = idle_q[rd_pos];
	assign rd_size = slot_size_q[rd_slot];

	ffbp_cmp u_cmp (
		.slot_size (rd_size),
		.req_size  (size_q),
		.min_size  (min_size_q),
		.res       (cmp)
	);

	always_comb begin
		free_idx = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end
	assign free_any = ~&in_use_q;

	assign hsel   = handle_q[SW-1:0];
	assign rel_ok = (int'(handle_q) < MAX_SLOTS) && in_use_q[hsel] && busy_q[hsel]
		&& (int'(idle_cnt_q) < MAX_SLOTS);

	always_comb begin
		state_d      = state_q;
		res_en       = 1'b0;
		res_status_d = ST_IGNORED;
		res_slot_d   = '0;
		res_size_d   = '0;
		scan_init    = 1'b0;
		scan_adv     = 1'b0;
		rel_en       = 1'b0;
		clr_en       = 1'b0;
		grant_en     = 1'b0;
		fresh_en     = 1'b0;
		size_wr_en   = 1'b0;
		drop_pos     = rd_pos;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_EMIT;
				res_en  = 1'b1;
				unique case (act_q)
					ACT_ACQUIRE: begin
						if (size_q == '0) begin
							res_status_d = ST_BAD_SIZE;
						end else begin
							res_en    = 1'b0;
							scan_init = 1'b1;
							state_d   = S_SCAN;
						end
					end
					ACT_RELEASE: begin
						rel_en       = rel_ok;
						res_status_d = rel_ok ? ST_RELEASED : ST_IGNORED;
					end
					ACT_CLEAR: begin
						clr_en       = 1'b1;
						res_status_d = ST_CLEARED;
					end
					default: begin
						res_status_d = ST_IGNORED;
					end
				endcase
			end
			S_SCAN: begin
				if (k_q < idle_cnt_q) begin
					if (cmp.ge_req) begin
						grant_en     = 1'b1;
						res_en       = 1'b1;
						res_status_d = ST_REUSED;
						res_slot_d   = rd_slot;
						res_size_d   = rd_size;
						state_d      = S_EMIT;
					end else begin
						scan_adv = 1'b1;
					end
				end else begin
					state_d = S_FRESH;
				end
			end
			S_FRESH: begin
				if ((CAP_W'(used_cnt_q) < cap_q) && free_any) begin
					fresh_en     = 1'b1;
					size_wr_en   = 1'b1;
					res_en       = 1'b1;
					res_status_d = ST_NEW;
					res_slot_d   = free_idx;
					res_size_d   = size_q;
					state_d      = S_EMIT;
				end else if (have_min_q) begin
					state_d = S_RECLAIM;
				end else begin
					res_en       = 1'b1;
					res_status_d = ST_FULL;
					state_d      = S_EMIT;
				end
			end
			S_RECLAIM: begin
				grant_en     = 1'b1;
				size_wr_en   = 1'b1;
				res_en       = 1'b1;
				res_status_d = ST_RECLAIMED;
				res_slot_d   = rd_slot;
				res_size_d   = size_q;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign min_upd = scan_adv && (!have_min_q || cmp.lt_min);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q    <= s_tdata[1:0];
			size_q   <= s_tdata[32:2];
			handle_q <= s_tdata[36:33];
		end
		if (scan_init) begin
			k_q <= '0;
		end else if (scan_adv) begin
			k_q <= k_q + 1'b1;
		end
		if (min_upd) begin
			min_size_q <= rd_size;
			min_pos_q  <= k_q[SW-1:0];
		end
		if (res_en) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
			res_size_q   <= res_size_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_min_q <= 1'b0;
		end else if (scan_init) begin
			have_min_q <= 1'b0;
		end else if (scan_adv) begin
			have_min_q <= 1'b1;
		end
	end

	// Size store: written on a fresh slot or a reclaim
	always_ff @(posedge clk) begin
		if (size_wr_en) begin
			slot_size_q[res_slot_d] <= size_q;
		end
	end

	// Idle list: close the gap at drop_pos all at once on a grant, append on release
	always_ff @(posedge clk) begin
		if (grant_en) begin
			for (int j = 0; j < NSLOT - 1; j++) begin
				if (SW'(j) >= drop_pos) begin
					idle_q[j] <= idle_q[j+1];
				end
			end
		end else if (rel_en) begin
			idle_q[idle_cnt_q[SW-1:0]] <= hsel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= '0;
			busy_q     <= '0;
			idle_cnt_q <= '0;
			used_cnt_q <= '0;
		end else if (clr_en) begin
			in_use_q   <= '0;
			busy_q     <= '0;
			idle_cnt_q <= '0;
			used_cnt_q <= '0;
		end else if (rel_en) begin
			busy_q[hsel] <= 1'b0;
			idle_cnt_q   <= idle_cnt_q + 1'b1;
		end else if (grant_en) begin
			busy_q[rd_slot] <= 1'b1;
			idle_cnt_q      <= idle_cnt_q - 1'b1;
		end else if (fresh_en) begin
			in_use_q[free_idx] <= 1'b1;
			busy_q[free_idx]   <= 1'b1;
			used_cnt_q         <= used_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, res_size_q, HANDLE_W'(res_slot_q), res_status_q};
		end
	end

	a_busy_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q & ~in_use_q) == '0)
		else $error("busy slot not in use");

	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_use_q) == int'(used_cnt_q))
		else $error("used count out of step with in-use marks");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_use_q & ~busy_q) == int'(idle_cnt_q))
		else $error("idle count out of step with idle slots");

	a_zero_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] > ST_RECLAIMED)) |-> (m_tdata[37:3] == '0))
		else $error("grant fields set on a result without a grant");

endmodule

[tb/sv/pool_checker.sv]
module pool_checker #(
	parameter int SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// s_tdata: action[1:0], request_size[32:2], handle[36:33], zero pad
	input  logic [ffbp_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata: status[2:0], granted_handle[6:3], granted_size[37:7], zero pad
	input  logic [ffbp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ffbp_pkg::PADDR_W-1:0]        paddr,
	input  logic [ffbp_pkg::PDATA_W-1:0]        pwdata,
	input  logic                                pready,
	output int                                  fail_count,
	output int                                  pending_count
);
	import ffbp_pkg::*;

	localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * REG_CAP_IDX);

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
	} pool_reply_t;

	logic [SIZE_W-1:0]   slot_size [SLOTS];
	logic                slot_open [SLOTS];
	logic                slot_busy [SLOTS];
	logic [HANDLE_W-1:0] idle_list [SLOTS];
	int                  idle_n;
	int                  open_n;
	logic [CAP_W-1:0]    capacity;
	pool_reply_t         replies_due [$];

	function automatic void empty_pool();
		for (int k = 0; k < SLOTS; k++) begin
			slot_size[k] = '0;
			slot_open[k] = 1'b0;
			slot_busy[k] = 1'b0;
			idle_list[k] = '0;
		end
		idle_n = 0;
		open_n = 0;
	endfunction

	function automatic void drop_idle(int pos);
		for (int k = pos; k + 1 < idle_n; k++)
			idle_list[k] = idle_list[k + 1];
		idle_n--;
	endfunction

	function automatic pool_reply_t predict_pool_op(logic [1:0] act, logic [SIZE_W-1:0] size,
			logic [HANDLE_W-1:0] hdl);
		pool_reply_t         r;
		int                  fit_pos;
		int                  min_pos;
		int                  cap_eff;
		int                  k;
		logic [SIZE_W-1:0]   min_size;
		logic [HANDLE_W-1:0] s;
		r = '{ST_IGNORED, '0, '0};
		fit_pos = -1;
		min_pos = -1;
		min_size = '0;
		s = '0;
		case (act)
			ACT_ACQUIRE: begin
				if (size == '0) begin
					r.status = ST_BAD_SIZE;
				end else begin
					// oldest idle entry that covers the request wins; track the first smallest
					for (k = 0; k < idle_n && fit_pos < 0; k++) begin
						s = idle_list[k];
						if (slot_size[s] >= size) begin
							fit_pos = k;
						end else if (min_pos < 0 || slot_size[s] < min_size) begin
							min_pos = k;
							min_size = slot_size[s];
						end
					end
					cap_eff = (capacity > SLOTS) ? SLOTS : capacity;
					if (fit_pos >= 0) begin
						s = idle_list[fit_pos];
						drop_idle(fit_pos);
						slot_busy[s] = 1'b1;
						r = '{ST_REUSED, s, slot_size[s]};
					end else if (open_n < cap_eff) begin
						for (k = SLOTS - 1; k >= 0; k--)
							if (!slot_open[k])
								s = HANDLE_W'(k);
						slot_open[s] = 1'b1;
						slot_busy[s] = 1'b1;
						slot_size[s] = size;
						open_n++;
						r = '{ST_NEW, s, size};
					end else if (min_pos >= 0) begin
						s = idle_list[min_pos];
						drop_idle(min_pos);
						slot_busy[s] = 1'b1;
						slot_size[s] = size;
						r = '{ST_RECLAIMED, s, size};
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			ACT_RELEASE: begin
				if (slot_open[hdl] && slot_busy[hdl] && idle_n < SLOTS) begin
					slot_busy[hdl] = 1'b0;
					idle_list[idle_n] = hdl;
					idle_n++;
					r.status = ST_RELEASED;
				end
			end
			ACT_CLEAR: begin
				empty_pool();
				r.status = ST_CLEARED;
			end
			default: r.status = ST_IGNORED;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pool_reply_t got;
		pool_reply_t want;
		pool_reply_t due;
		if (!arst_n) begin
			empty_pool();
			capacity = CAP_RESET;
			replies_due.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
				capacity = pwdata[CAP_W-1:0];
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tdata[2:0]);
				got.handle = m_tdata[6:3];
				got.size   = m_tdata[37:7];
				if (replies_due.size() == 0) begin
					$error("result transfer with no request outstanding: status %0d",
						got.status);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.handle !== want.handle) begin
						$error("granted_handle: expected %0d, actual %0d",
							want.handle, got.handle);
						fail_count++;
					end
					if (got.size !== want.size) begin
						$error("granted_size: expected %0d, actual %0d", want.size, got.size);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				due = predict_pool_op(s_tdata[1:0], s_tdata[32:2], s_tdata[36:33]);
				replies_due.insert(replies_due.size(), due);
			end
			pending_count = replies_due.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
module testbench;
	import ffbp_pkg::*;

	localparam int POOL_SLOTS  = 16;
	localparam int RANDOM_OPS  = 1900;
	localparam int PHASES      = 12;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [PADDR_W-1:0] CAP_ADDR    = PADDR_W'(4 * REG_CAP_IDX);
	localparam logic [1:0]         ACT_UNKNOWN = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// s_tdata: action[1:0], request_size[32:2], handle[36:33], zero pad
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// m_tdata: status[2:0], granted_handle[6:3], granted_size[37:7], zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	int fail_count;
	int pending_count;
	int cycle_count = 0;
	int results_seen = 0;
	int cap_now;
	bit tx_calm;
	bit rx_calm;

	first_fit_buffer_pool_core #(
		.MAX_SLOTS(POOL_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pool_checker #(
		.SLOTS(POOL_SLOTS)
	) pool_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (m_tvalid && m_tready)
			results_seen++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** first_fit_buffer_pool_core: FAILED **");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 75)
			return SIZE_W'($urandom_range(1, 64));
		if (r < 82)
			return $urandom_range(0, 1) ? SIZE_W'(1) : {SIZE_W{1'b1}};
		return SIZE_W'($urandom);
	endfunction

	task automatic send_op(input logic [1:0] act, input logic [SIZE_W-1:0] size,
			input logic [HANDLE_W-1:0] hdl);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {3'b000, hdl, size, act};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_op();
		int r;
		int span;
		r = $urandom_range(0, 99);
		span = (cap_now == 0 || cap_now > POOL_SLOTS) ? POOL_SLOTS : cap_now;
		if (r < 52)
			send_op(ACT_ACQUIRE, pick_size(), HANDLE_W'($urandom));
		else if (r < 94)
			send_op(ACT_RELEASE, SIZE_W'($urandom), HANDLE_W'(($urandom_range(0, 6) == 0) ?
				$urandom_range(0, POOL_SLOTS - 1) : $urandom_range(0, span - 1)));
		else if (r < 97)
			send_op(ACT_CLEAR, SIZE_W'($urandom), HANDLE_W'($urandom));
		else
			send_op(ACT_UNKNOWN, SIZE_W'($urandom), HANDLE_W'($urandom));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_count == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input int cap);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = CAP_ADDR;
		pwdata  = $urandom_range(0, 1) ? $urandom : 0;
		pwdata[CAP_W-1:0] = CAP_W'(cap);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		cap_now = cap;
	endtask

	// output side: random stalls, calm stretches, and two long hold-offs
	initial begin : receiver
		int gap_left;
		int hold_left;
		int holds_done;
		gap_left = 0;
		hold_left = 0;
		holds_done = 0;
		m_tready = 1'b0;
		rx_calm = 1'b0;
		forever begin
			@(negedge clk);
			if ((holds_done == 0 && results_seen >= 150) ||
					(holds_done == 1 && results_seen >= 1200)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (cycle_count % 256 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					gap_left = pick_gap();
			end
		end
	end

	initial begin
		int cap;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		tx_calm  = 1'b0;
		cap_now  = CAP_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_op(ACT_ACQUIRE, '0, '0);
		send_op(ACT_RELEASE, '0, 4'd0);
		send_op(ACT_ACQUIRE, {SIZE_W{1'b1}}, '0);
		send_op(ACT_ACQUIRE, SIZE_W'(1), '0);
		send_op(ACT_ACQUIRE, SIZE_W'(100), 4'hF);
		send_op(ACT_RELEASE, '0, 4'd1);
		send_op(ACT_RELEASE, '0, 4'd1);
		send_op(ACT_ACQUIRE, SIZE_W'(1), '0);
		send_op(ACT_RELEASE, '0, 4'd0);
		send_op(ACT_RELEASE, '0, 4'd2);
		// oldest idle slot fits and grants its full recorded size
		send_op(ACT_ACQUIRE, SIZE_W'(50), '0);
		send_op(ACT_RELEASE, {SIZE_W{1'b1}}, 4'hF);
		send_op(ACT_UNKNOWN, SIZE_W'(7), 4'd3);
		send_op(ACT_CLEAR, '0, '0);
		wait_idle();
		write_capacity(2);
		send_op(ACT_ACQUIRE, SIZE_W'(10), '0);
		send_op(ACT_ACQUIRE, SIZE_W'(10), '0);
		send_op(ACT_ACQUIRE, SIZE_W'(5), '0);
		send_op(ACT_RELEASE, '0, 4'd1);
		send_op(ACT_RELEASE, '0, 4'd0);
		// equal sizes: reclaim takes the older idle entry first
		send_op(ACT_ACQUIRE, SIZE_W'(30), '0);
		send_op(ACT_ACQUIRE, SIZE_W'(40), '0);
		wait_idle();
		write_capacity(0);
		send_op(ACT_ACQUIRE, SIZE_W'(3), '0);
		send_op(ACT_RELEASE, '0, 4'd0);
		send_op(ACT_ACQUIRE, SIZE_W'(3), '0);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0:       cap = 16;
				1:       cap = 31;
				2:       cap = 0;
				3:       cap = 2;
				4:       cap = 1;
				5:       cap = 8;
				6:       cap = 3;
				7:       cap = 31;
				8:       cap = 16;
				9:       cap = 5;
				10:      cap = 15;
				default: cap = $urandom_range(0, 31);
			endcase
			write_capacity(cap);
			tx_calm = ($urandom_range(0, 3) == 0);
			repeat (RANDOM_OPS / PHASES) random_op();
		end
		wait_idle();
		repeat (25) @(posedge clk);
		if (fail_count == 0)
			$display("** first_fit_buffer_pool_core: PASSED **");
		else
			$display("** first_fit_buffer_pool_core: FAILED **");
		$finish;
	end

endmodule
